>>> design/backward_lzss_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// Backward LZSS decoder assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BACKWARD_LZSS_DECODER_TOP_DEFINES_SVH
`define BACKWARD_LZSS_DECODER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BLZD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BLZD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/blzd_pkg.sv
// ----------------------------------------------------------------------------
// Backward LZSS decoder package
// Sizes, codes, command/status types and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package blzd_pkg;

    localparam int HISTORY_DEPTH = 16384;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int BUFFER_BITS   = 32;
    localparam int BCNT_W        = $clog2(BUFFER_BITS + 1);
    localparam int LEN_W         = 28;
    localparam int PROD_W        = 29;
    localparam int OFS_W         = 13;
    localparam int DIST_W        = OFS_W + 1;
    localparam int COPY_W        = 32;
    localparam int FIELD_W       = 13;
    localparam int FW_W          = 4;
    localparam int STATUS_W      = 3;
    localparam int BYTE_W        = 8;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_BYTE   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECT = 3'd4;

    // Token parse phases.
    localparam logic [2:0] PH_FLAG = 3'd0;
    localparam logic [2:0] PH_LIT  = 3'd1;
    localparam logic [2:0] PH_OFS  = 3'd2;
    localparam logic [2:0] PH_L2   = 3'd3;
    localparam logic [2:0] PH_L3   = 3'd4;
    localparam logic [2:0] PH_L5   = 3'd5;
    localparam logic [2:0] PH_L8   = 3'd6;
    localparam logic [2:0] PH_COPY = 3'd7;

    typedef struct packed {
        logic                latch;
        logic                append;
        logic                take;
        logic                set_ofs;
        logic                add_len;
        logic                copy_rd;
        logic                emit_lit;
        logic                emit_copy;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic                out_load;
    } blzd_cmd_t;

    typedef struct packed {
        logic               kind;
        logic               reject;
        logic               done;
        logic               need;
        logic [FIELD_W-1:0] field_v;
        logic               copy_last;
    } blzd_stat_t;

    // Mask with the low n bits set.
    function automatic logic [BUFFER_BITS-1:0] low_mask(input logic [BCNT_W-1:0] n);
        logic [BUFFER_BITS-1:0] m;
        for (int i = 0; i < BUFFER_BITS; i++) begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

    // Width of the bit field read in a given phase.
    function automatic logic [FW_W-1:0] field_width(input logic [2:0] ph);
        logic [FW_W-1:0] w;
        unique case (ph)
            PH_FLAG: w = 4'd1;
            PH_LIT:  w = 4'd8;
            PH_OFS:  w = 4'd13;
            PH_L2:   w = 4'd2;
            PH_L3:   w = 4'd3;
            PH_L5:   w = 4'd5;
            PH_L8:   w = 4'd8;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    // True when a field of width w is all ones.
    function automatic logic field_full(input logic [FW_W-1:0] w,
                                        input logic [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] m;
        for (int i = 0; i < FIELD_W; i++) begin
            m[i] = (i < int'(w));
        end
        return (v == m);
    endfunction

endpackage

`default_nettype wire

>>> design/blzd_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries compressed bytes and pull requests into the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface blzd_req_if;
    import blzd_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic              final_byte;

    modport source(output valid, kind, data_byte, final_byte, input ready);
    modport sink(input valid, kind, data_byte, final_byte, output ready);
endinterface

`default_nettype wire

>>> design/blzd_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries one result per request out of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface blzd_rsp_if;
    import blzd_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   out_byte;
    logic                last_out;

    modport source(output valid, status, out_byte, last_out, input ready);
    modport sink(input valid, status, out_byte, last_out, output ready);
endinterface

`default_nettype wire

>>> design/blzd_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Writes the output length register.
// ----------------------------------------------------------------------------
`default_nettype none

interface blzd_cfg_if;
    import blzd_pkg::*;

    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] output_length;

    modport source(output valid, output_length, input ready);
    modport sink(input valid, output_length, output ready);
endinterface

`default_nettype wire

>>> design/blzd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module blzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

>>> design/blzd_ctrl.sv
// ----------------------------------------------------------------------------
// Decoder controller
// Sequences one request at a time: decide, parse fields, copy, deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module blzd_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic                out_ready,
    output logic                     out_valid,
    input  wire blzd_pkg::blzd_stat_t stat,
    output blzd_pkg::blzd_cmd_t      cmd,
    output logic [blzd_pkg::FW_W-1:0] field_w
);
    import blzd_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_PARSE  = 3'd2;
    localparam logic [2:0] S_COPY   = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    logic       full;

    // The field width follows the parse phase alone.
    assign field_w = field_width(phase_reg);
    assign full    = field_full(field_w, stat.field_v);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!stat.kind)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = stat.reject ? ST_REJECT : ST_ACCEPT;
                    cmd.append     = !stat.reject;
                    state_next     = S_RESULT;
                end
                else if (stat.done)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_DONE;
                    state_next     = S_RESULT;
                end
                else
                begin
                    state_next = S_PARSE;
                end
            end
            S_PARSE:
            begin
                if (phase_reg == PH_COPY)
                begin
                    cmd.copy_rd = 1'b1;
                    if (stat.copy_last)
                    begin
                        phase_next = PH_FLAG;
                    end
                    state_next = S_COPY;
                end
                else if (stat.need)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NEED;
                    state_next     = S_RESULT;
                end
                else
                begin
                    cmd.take = 1'b1;
                    unique case (phase_reg)
                        PH_FLAG: phase_next = stat.field_v[0] ? PH_OFS : PH_LIT;
                        PH_LIT:
                        begin
                            cmd.emit_lit = 1'b1;
                            phase_next   = PH_FLAG;
                            state_next   = S_RESULT;
                        end
                        PH_OFS:
                        begin
                            cmd.set_ofs = 1'b1;
                            phase_next  = PH_L2;
                        end
                        PH_L2:
                        begin
                            cmd.add_len = 1'b1;
                            phase_next  = full ? PH_L3 : PH_COPY;
                        end
                        PH_L3:
                        begin
                            cmd.add_len = 1'b1;
                            phase_next  = full ? PH_L5 : PH_COPY;
                        end
                        PH_L5:
                        begin
                            cmd.add_len = 1'b1;
                            phase_next  = full ? PH_L8 : PH_COPY;
                        end
                        default:
                        begin
                            cmd.add_len = 1'b1;
                            phase_next  = full ? PH_L8 : PH_COPY;
                        end
                    endcase
                end
            end
            S_COPY:
            begin
                cmd.emit_copy = 1'b1;
                state_next    = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_FLAG;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
endmodule

`default_nettype wire

>>> design/blzd_datapath.sv
// ----------------------------------------------------------------------------
// Decoder datapath
// Bit buffer, field extraction, match length, history memory and result.
// ----------------------------------------------------------------------------
`default_nettype none

module blzd_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_kind,
    input  wire logic [blzd_pkg::BYTE_W-1:0]  in_data_byte,
    input  wire logic                         in_final_byte,
    input  wire logic                         cfg_valid,
    input  wire logic [blzd_pkg::LEN_W-1:0]   cfg_length,
    input  wire blzd_pkg::blzd_cmd_t          cmd,
    input  wire logic [blzd_pkg::FW_W-1:0]    field_w,
    output blzd_pkg::blzd_stat_t              stat,
    output logic [blzd_pkg::STATUS_W-1:0]     out_status,
    output logic [blzd_pkg::BYTE_W-1:0]       out_byte,
    output logic                              out_last
);
    import blzd_pkg::*;

    localparam logic [HIST_AW:0] DEPTH_W = (HIST_AW + 1)'(HISTORY_DEPTH);
    localparam logic [HIST_AW-1:0] WPTR_MAX = HIST_AW'(HISTORY_DEPTH - 1);
    localparam logic [BCNT_W-1:0] APPEND_LIMIT = BCNT_W'(BUFFER_BITS - BYTE_W);

    logic                   kind_reg;
    logic [BYTE_W-1:0]      byte_reg;
    logic                   final_reg;
    logic [BUFFER_BITS-1:0] buf_reg;
    logic [BCNT_W-1:0]      cnt_reg;
    logic                   ended_reg;
    logic [OFS_W-1:0]       ofs_reg;
    logic [COPY_W-1:0]      copy_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [HIST_AW-1:0]     wptr_reg;
    logic [LEN_W-1:0]       len_reg;
    logic                   src_ok_reg;
    logic [STATUS_W-1:0]    res_status_reg;
    logic [BYTE_W-1:0]      res_byte_reg;
    logic                   res_last_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [BYTE_W-1:0]      out_byte_reg;
    logic                   out_last_reg;

    logic [BCNT_W-1:0]      n_req, n_eff, cnt_after;
    logic                   short_bits;
    logic [BUFFER_BITS-1:0] shifted, fmask;
    logic [FIELD_W-1:0]     field_v;
    logic [COPY_W:0]        len_sum;
    logic [DIST_W-1:0]      src_dist;
    logic [HIST_AW:0]       raddr_wide;
    logic [HIST_AW-1:0]     raddr;
    logic                   emit;
    logic [BYTE_W-1:0]      emit_byte;
    logic [BYTE_W-1:0]      ram_rdata;
    logic [PROD_W-1:0]      prod_inc;

    // Field extraction: MSB first from the valid low bits of the buffer.
    assign n_req      = BCNT_W'(field_w);
    assign short_bits = (cnt_reg < n_req);
    assign n_eff      = short_bits ? cnt_reg : n_req;
    assign cnt_after  = cnt_reg - n_eff;
    assign shifted    = buf_reg >> cnt_after;
    assign fmask      = low_mask(n_eff);
    assign field_v    = shifted[FIELD_W-1:0] & fmask[FIELD_W-1:0];

    assign len_sum = {1'b0, copy_reg} + (COPY_W + 1)'(field_v);

    // Copy source: offset + 2 bytes back, wrapping around the history.
    assign src_dist   = DIST_W'(ofs_reg) + DIST_W'(2);
    assign raddr_wide = ({1'b0, wptr_reg} >= (HIST_AW + 1)'(src_dist))
                      ? ({1'b0, wptr_reg} - (HIST_AW + 1)'(src_dist))
                      : ({1'b0, wptr_reg} + DEPTH_W - (HIST_AW + 1)'(src_dist));
    assign raddr      = raddr_wide[HIST_AW-1:0];

    assign emit      = cmd.emit_lit || cmd.emit_copy;
    assign emit_byte = cmd.emit_copy ? (src_ok_reg ? ram_rdata : '0) : field_v[BYTE_W-1:0];
    assign prod_inc  = prod_reg + PROD_W'(1);

    blzd_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .clk  (clk),
        .we   (emit),
        .waddr(wptr_reg),
        .wdata(emit_byte),
        .re   (cmd.copy_rd),
        .raddr(raddr),
        .rdata(ram_rdata)
    );

    assign stat.kind      = kind_reg;
    assign stat.reject    = ended_reg || (cnt_reg > APPEND_LIMIT);
    assign stat.done      = (prod_reg >= PROD_W'(len_reg));
    assign stat.need      = short_bits && !ended_reg;
    assign stat.field_v   = field_v;
    assign stat.copy_last = (copy_reg == COPY_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= '0;
            cnt_reg   <= '0;
            ended_reg <= 1'b0;
            ofs_reg   <= '0;
            copy_reg  <= '0;
            prod_reg  <= '0;
            wptr_reg  <= '0;
            len_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                len_reg <= cfg_length;
            end
            if (cmd.append)
            begin
                buf_reg   <= {buf_reg[BUFFER_BITS-BYTE_W-1:0], byte_reg};
                cnt_reg   <= cnt_reg + BCNT_W'(BYTE_W);
                ended_reg <= ended_reg || final_reg;
            end
            if (cmd.take)
            begin
                cnt_reg <= cnt_after;
                buf_reg <= buf_reg & low_mask(cnt_after);
            end
            if (cmd.set_ofs)
            begin
                ofs_reg  <= field_v;
                copy_reg <= COPY_W'(3);
            end
            if (cmd.add_len)
            begin
                copy_reg <= len_sum[COPY_W] ? '1 : len_sum[COPY_W-1:0];
            end
            if (cmd.copy_rd)
            begin
                copy_reg <= copy_reg - COPY_W'(1);
            end
            if (emit)
            begin
                prod_reg <= prod_inc;
                wptr_reg <= (wptr_reg == WPTR_MAX) ? '0 : wptr_reg + HIST_AW'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg  <= in_kind;
            byte_reg  <= in_data_byte;
            final_reg <= in_final_byte;
        end
        if (cmd.copy_rd)
        begin
            src_ok_reg <= (prod_reg >= PROD_W'(src_dist));
        end
        if (emit)
        begin
            res_status_reg <= ST_BYTE;
            res_byte_reg   <= emit_byte;
            res_last_reg   <= (prod_inc == PROD_W'(len_reg));
        end
        else if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_byte_reg   <= '0;
            res_last_reg   <= 1'b0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_byte_reg   <= res_byte_reg;
            out_last_reg   <= res_last_reg;
        end
    end

    assign out_status = out_status_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
endmodule

`default_nettype wire

>>> design/backward_lzss_decoder_top.sv
// Backward LZSS decoder. Each request on req gives exactly one result on rsp.
// A request with kind 0 offers one compressed byte (highest address first) and
// passes from acceptance through the decide state to the result state, as does
// a pull answered done. Any other pull also passes through the parse state,
// which takes the token fields (flag, literal, offset, length fields, one field
// per cycle) and can end the request in need input; a match copy byte adds a
// read request to the 16384-byte history memory and then the copy state, which
// takes the registered read data. The controller works on one request at a
// time and is ready again from the clock edge at which the result enters the
// output register, so a new request is accepted while the previous result
// waits on rsp; a finished result that still finds the output register occupied
// waits until rsp takes the old one. The output length register is written
// through cfg, which is always ready, and should only be written while no
// request is in flight.
// ----------------------------------------------------------------------------
// Backward LZSS decoder top level
// Joins the request sequencer, the decode datapath and the three channels.
// ----------------------------------------------------------------------------
`default_nettype none

module backward_lzss_decoder_top (
    input  wire logic clk,
    input  wire logic rst_n,
    blzd_req_if.sink  req,
    blzd_rsp_if.source rsp,
    blzd_cfg_if.sink  cfg
);
    import blzd_pkg::*;

    blzd_cmd_t       cmd;
    blzd_stat_t      stat;
    logic [FW_W-1:0] field_w;

    // The length register can take a write in any cycle.
    assign cfg.ready = 1'b1;

    // The controller owns the request and response handshakes and the parse
    // phase; it accepts a request only when idle and keeps the response valid
    // bit. It also gives the width of the field that the current phase reads.
    blzd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req.valid),
        .req_ready(req.ready),
        .out_ready(rsp.ready),
        .out_valid(rsp.valid),
        .stat     (stat),
        .cmd      (cmd),
        .field_w  (field_w)
    );

    // The datapath holds the bit buffer, match state, byte count, history
    // memory and the result and output payload registers.
    blzd_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_kind      (req.kind),
        .in_data_byte (req.data_byte),
        .in_final_byte(req.final_byte),
        .cfg_valid    (cfg.valid),
        .cfg_length   (cfg.output_length),
        .cmd          (cmd),
        .field_w      (field_w),
        .stat         (stat),
        .out_status   (rsp.status),
        .out_byte     (rsp.out_byte),
        .out_last     (rsp.last_out)
    );
endmodule

`default_nettype wire

>>> design/blzd_checker.sv
// ----------------------------------------------------------------------------
// Decoder port checker
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "backward_lzss_decoder_top_defines.svh"

module blzd_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_ready,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire logic [blzd_pkg::STATUS_W-1:0]   rsp_status,
    input wire logic [blzd_pkg::BYTE_W-1:0]     rsp_out_byte,
    input wire logic                            rsp_last_out
);
    import blzd_pkg::*;

    // Only a decoded byte carries data or the last marker.
    `BLZD_ASSERT_SAME(a_payload_clean, rsp_valid && (rsp_status != ST_BYTE),
        (rsp_out_byte == '0) && !rsp_last_out, "non-byte result carries data")

    // One request is worked on at a time.
    `BLZD_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
        "request accepted while previous one still in work")

    // A stalled result keeps its payload.
    `BLZD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_status) && $stable(rsp_out_byte) && $stable(rsp_last_out),
        "stalled result changed")
endmodule

bind backward_lzss_decoder_top blzd_checker u_blzd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_status  (rsp.status),
    .rsp_out_byte(rsp.out_byte),
    .rsp_last_out(rsp.last_out)
);

`default_nettype wire
